### rtl/riff_wave_chunk_parser_defines.svh
// Assertion macros for the RIFF/WAVE chunk parser.
`ifndef RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RWCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwcp: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define RWCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwcp: next-cycle check failed");
`else
`define RWCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RWCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rwcp_pkg.sv
`default_nettype none

package rwcp_pkg;

  typedef enum logic [2:0] {
    ST_PENDING       = 3'd0,
    ST_FOUND         = 3'd1,
    ST_NOT_RIFF      = 3'd2,
    ST_NOT_WAVE      = 3'd3,
    ST_SIZE_MISMATCH = 3'd4,
    ST_FMT_SHORT     = 3'd5,
    ST_MISSING       = 3'd6,
    ST_IGNORED       = 3'd7
  } status_e;

  // Tags as little-endian 32-bit words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd14;
  // RIFF header size: tag plus length word
  localparam logic [32:0] RIFF_HDR_LEN = 33'd8;
  // Offset of the first chunk header after the WAVE tag
  localparam logic [32:0] FIRST_CK_POS = 33'd12;

endpackage

`default_nettype wire

### rtl/rwcp_if.sv
`default_nettype none

interface rwcp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] file_length;

  modport source (output valid, byte_value, first_byte, last_byte, file_length, input ready);
  modport sink   (input valid, byte_value, first_byte, last_byte, file_length, output ready);
endinterface

interface rwcp_stat_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] format_offset;
  logic [31:0] data_offset;
  logic [31:0] data_length;

  modport source (output valid, status, format_offset, data_offset, data_length, input ready);
  modport sink   (input valid, status, format_offset, data_offset, data_length, output ready);
endinterface

`default_nettype wire

### rtl/riff_wave_chunk_parser.sv
// Output: each status result is registered; the output register takes it as its byte transfers.
// Throughput: one byte per cycle; the parser state and the output register both update
// on the same edge, so the only stall is a full output register with ready low.
// Reset: asynchronous, active low; the parser goes idle and reports ignored bytes until
// a byte marked first_byte arrives. No memory, no clearing pass.
`default_nettype none

`include "riff_wave_chunk_parser_defines.svh"

module riff_wave_chunk_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rwcp_byte_if.sink          byte_i,
  rwcp_stat_if.source        stat_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RIFF_TAG,
    PH_RIFF_LEN,
    PH_WAVE_TAG,
    PH_CK_TAG,
    PH_CK_LEN,
    PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [32:0] pos_q, pos_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  logic [31:0] tag_q, tag_d;
  logic [32:0] end_q, end_d;
  logic [31:0] total_q, total_d;
  logic [32:0] skip_q, skip_d;
  logic        fseen_q, fseen_d;
  logic        dseen_q, dseen_d;
  logic [31:0] fo_q, fo_d;
  logic [31:0] do_q, do_d;
  logic [31:0] dlen_q, dlen_d;

  logic                 out_valid_q, out_valid_d;
  rwcp_pkg::status_e    out_status_q, out_status_d;
  logic [31:0]          out_fo_q, out_fo_d;
  logic [31:0]          out_do_q, out_do_d;
  logic [31:0]          out_dlen_q, out_dlen_d;

  rwcp_pkg::status_e    status;
  logic                 in_ready;
  logic                 in_accept;

  // view of the state with first_byte applied
  phase_e      cur_phase;
  logic [32:0] cur_pos;
  logic [1:0]  cur_cnt;
  logic [31:0] cur_total;
  logic        cur_fseen;
  logic        cur_dseen;
  logic [31:0] cur_dlen;

  logic [31:0] full_word;
  logic [32:0] payload;
  logic [32:0] padded;
  logic [33:0] next_off;

  assign in_ready  = !out_valid_q || stat_o.ready;
  assign in_accept = byte_i.valid && in_ready;

  assign cur_phase = byte_i.first_byte ? PH_RIFF_TAG : phase_q;
  assign cur_pos   = byte_i.first_byte ? 33'd0 : pos_q;
  assign cur_cnt   = byte_i.first_byte ? 2'd0 : cnt_q;
  assign cur_total = byte_i.first_byte ? byte_i.file_length : total_q;
  assign cur_fseen = byte_i.first_byte ? 1'b0 : fseen_q;
  assign cur_dseen = byte_i.first_byte ? 1'b0 : dseen_q;
  assign cur_dlen  = byte_i.first_byte ? 32'd0 : dlen_q;

  assign full_word = {byte_i.byte_value, word_q[31:8]};
  assign payload   = cur_pos + 33'd1;
  // round the chunk length up to even, without wrap
  assign padded    = {1'b0, full_word} + {32'd0, full_word[0]};
  assign next_off  = {1'b0, payload} + {1'b0, padded};

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    tag_d   = tag_q;
    end_d   = end_q;
    total_d = total_q;
    skip_d  = skip_q;
    fseen_d = fseen_q;
    dseen_d = dseen_q;
    fo_d    = fo_q;
    do_d    = do_q;
    dlen_d  = dlen_q;
    status  = rwcp_pkg::ST_PENDING;

    if (in_accept) begin
      if (byte_i.first_byte) begin
        fseen_d = 1'b0;
        dseen_d = 1'b0;
        fo_d    = '0;
        do_d    = '0;
        dlen_d  = '0;
        total_d = byte_i.file_length;
      end
      phase_d = cur_phase;

      case (cur_phase)
        PH_IDLE: begin
          status = rwcp_pkg::ST_IGNORED;
        end
        PH_SKIP: begin
          skip_d = skip_q - 33'd1;
          if (skip_q == 33'd1) begin
            phase_d = PH_CK_TAG;
          end
        end
        default: begin
          word_d = full_word;
          cnt_d  = cur_cnt + 2'd1;
          if (cur_cnt == 2'd3) begin
            case (cur_phase)
              PH_RIFF_TAG: begin
                if (full_word != rwcp_pkg::TAG_RIFF) begin
                  status = rwcp_pkg::ST_NOT_RIFF;
                end else begin
                  phase_d = PH_RIFF_LEN;
                end
              end
              PH_RIFF_LEN: begin
                end_d   = {1'b0, full_word} + rwcp_pkg::RIFF_HDR_LEN;
                phase_d = PH_WAVE_TAG;
              end
              PH_WAVE_TAG: begin
                if (full_word != rwcp_pkg::TAG_WAVE) begin
                  status = rwcp_pkg::ST_NOT_WAVE;
                end else if ({1'b0, cur_total} != end_q) begin
                  status = rwcp_pkg::ST_SIZE_MISMATCH;
                end else if (end_q <= rwcp_pkg::FIRST_CK_POS) begin
                  status = rwcp_pkg::ST_MISSING;
                end else begin
                  phase_d = PH_CK_TAG;
                end
              end
              PH_CK_TAG: begin
                tag_d   = full_word;
                phase_d = PH_CK_LEN;
              end
              PH_CK_LEN: begin
                if (tag_q == rwcp_pkg::TAG_FMT && !cur_fseen) begin
                  if (full_word < rwcp_pkg::FMT_MIN_LEN) begin
                    status = rwcp_pkg::ST_FMT_SHORT;
                  end else begin
                    fseen_d = 1'b1;
                    fo_d    = payload[31:0];
                    if (cur_dseen && cur_dlen != 32'd0) begin
                      status = rwcp_pkg::ST_FOUND;
                    end
                  end
                end else if (tag_q == rwcp_pkg::TAG_DATA &&
                             (!cur_dseen || cur_dlen == 32'd0)) begin
                  dseen_d = 1'b1;
                  do_d    = payload[31:0];
                  dlen_d  = full_word;
                  if (cur_fseen) begin
                    status = rwcp_pkg::ST_FOUND;
                  end
                end
                if (status == rwcp_pkg::ST_PENDING) begin
                  // drop out once the next header would start at or past the declared end
                  if (next_off >= {1'b0, end_q}) begin
                    status = rwcp_pkg::ST_MISSING;
                  end else if (padded == 33'd0) begin
                    phase_d = PH_CK_TAG;
                  end else begin
                    skip_d  = padded;
                    phase_d = PH_SKIP;
                  end
                end
              end
              default: begin
                status = rwcp_pkg::ST_IGNORED;
              end
            endcase
          end
        end
      endcase

      if (cur_phase != PH_IDLE) begin
        pos_d = payload;
        if (status == rwcp_pkg::ST_PENDING && byte_i.last_byte) begin
          status = rwcp_pkg::ST_MISSING;
        end
      end
      if (status != rwcp_pkg::ST_PENDING) begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_fo_d     = out_fo_q;
    out_do_d     = out_do_q;
    out_dlen_d   = out_dlen_q;
    if (in_accept) begin
      out_valid_d  = 1'b1;
      out_status_d = status;
      if (status == rwcp_pkg::ST_FOUND) begin
        out_fo_d   = fo_d;
        out_do_d   = do_d;
        out_dlen_d = dlen_d;
      end else begin
        out_fo_d   = '0;
        out_do_d   = '0;
        out_dlen_d = '0;
      end
    end else if (stat_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      pos_q        <= '0;
      cnt_q        <= '0;
      word_q       <= '0;
      tag_q        <= '0;
      end_q        <= '0;
      total_q      <= '0;
      skip_q       <= '0;
      fseen_q      <= 1'b0;
      dseen_q      <= 1'b0;
      fo_q         <= '0;
      do_q         <= '0;
      dlen_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= rwcp_pkg::ST_PENDING;
      out_fo_q     <= '0;
      out_do_q     <= '0;
      out_dlen_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      cnt_q        <= cnt_d;
      word_q       <= word_d;
      tag_q        <= tag_d;
      end_q        <= end_d;
      total_q      <= total_d;
      skip_q       <= skip_d;
      fseen_q      <= fseen_d;
      dseen_q      <= dseen_d;
      fo_q         <= fo_d;
      do_q         <= do_d;
      dlen_q       <= dlen_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_fo_q     <= out_fo_d;
      out_do_q     <= out_do_d;
      out_dlen_q   <= out_dlen_d;
    end
  end

  assign byte_i.ready         = in_ready;
  assign stat_o.valid         = out_valid_q;
  assign stat_o.status        = out_status_q;
  assign stat_o.format_offset = out_fo_q;
  assign stat_o.data_offset   = out_do_q;
  assign stat_o.data_length   = out_dlen_q;

  `RWCP_ASSERT_IMP(a_fields_zero_unless_found, clk_i, rst_ni,
    out_valid_q && out_status_q != rwcp_pkg::ST_FOUND,
    out_fo_q == 32'd0 && out_do_q == 32'd0 && out_dlen_q == 32'd0)

  `RWCP_ASSERT_NXT(a_idle_reports_ignored, clk_i, rst_ni,
    in_accept && phase_q == PH_IDLE && !byte_i.first_byte,
    out_status_q == rwcp_pkg::ST_IGNORED)

  `RWCP_ASSERT_NXT(a_last_byte_ends_parse, clk_i, rst_ni,
    in_accept && byte_i.last_byte, phase_q == PH_IDLE)

  `RWCP_ASSERT_IMP(a_skip_count_live, clk_i, rst_ni,
    phase_q == PH_SKIP, skip_q != 33'd0)

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef enum logic [2:0] {
    W_IDLE, W_RIFF_TAG, W_RIFF_LEN, W_WAVE_TAG, W_CK_TAG, W_CK_LEN, W_SKIP
  } walk_e;

  typedef struct packed {
    logic [7:0]  value;
    logic        first;
    logic        last;
    logic [31:0] flen;
  } byte_item_t;

  typedef struct packed {
    rwcp_pkg::status_e status;
    logic [31:0]       fmt_off;
    logic [31:0]       data_off;
    logic [31:0]       data_len;
  } status_rec_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        src_valid = 1'b0;
  logic [7:0]  src_value = '0;
  logic        src_first = 1'b0;
  logic        src_last  = 1'b0;
  logic [31:0] src_flen  = '0;
  logic        snk_ready = 1'b0;

  rwcp_byte_if bif ();
  rwcp_stat_if sif ();

  assign bif.valid       = src_valid;
  assign bif.byte_value  = src_value;
  assign bif.first_byte  = src_first;
  assign bif.last_byte   = src_last;
  assign bif.file_length = src_flen;
  assign sif.ready       = snk_ready;

  riff_wave_chunk_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (bif),
    .stat_o (sif)
  );

  byte_item_t  byte_q[$];
  status_rec_t status_due_q[$];
  logic [7:0]  file_buf[$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_built  = 0;
  bit          calm         = 1'b0;

  // Parser shadow state
  walk_e       walk          = W_IDLE;
  logic [63:0] pos           = '0;
  int unsigned shift         = 0;
  logic [31:0] riff_len      = '0;
  logic [31:0] file_size     = '0;
  logic [31:0] tag_acc       = '0;
  logic [63:0] skip_left     = '0;
  bit          fmt_found     = 1'b0;
  bit          data_found    = 1'b0;
  logic [63:0] fmt_at        = '0;
  logic [63:0] data_at       = '0;
  logic [31:0] data_len_held = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rwcp_pkg::status_e close_chunk_header();
    logic [63:0] payload;
    logic [63:0] len;
    logic [63:0] padded;
    payload = pos + 64'd1;
    len     = skip_left;
    if (tag_acc == rwcp_pkg::TAG_FMT) begin
      if (!fmt_found) begin
        if (len < {32'd0, rwcp_pkg::FMT_MIN_LEN}) return rwcp_pkg::ST_FMT_SHORT;
        fmt_found = 1'b1;
        fmt_at    = payload;
        if (data_found && data_len_held != 32'd0) return rwcp_pkg::ST_FOUND;
      end
    end else if (tag_acc == rwcp_pkg::TAG_DATA) begin
      // a held data chunk with nonzero length is never replaced
      if (!data_found || data_len_held == 32'd0) begin
        data_found    = 1'b1;
        data_at       = payload;
        data_len_held = len[31:0];
        if (fmt_found) return rwcp_pkg::ST_FOUND;
      end
    end
    padded = (len + 64'd1) & ~64'd1;
    if (payload + padded >= {32'd0, riff_len} + 64'd8) return rwcp_pkg::ST_MISSING;
    tag_acc = '0;
    if (padded == 64'd0) begin
      walk = W_CK_TAG;
    end else begin
      skip_left = padded;
      walk      = W_SKIP;
    end
    return rwcp_pkg::ST_PENDING;
  endfunction

  function automatic rwcp_pkg::status_e close_word();
    case (walk)
      W_RIFF_TAG: begin
        if (tag_acc != rwcp_pkg::TAG_RIFF) return rwcp_pkg::ST_NOT_RIFF;
        walk = W_RIFF_LEN;
      end
      W_RIFF_LEN: begin
        tag_acc = '0;
        walk    = W_WAVE_TAG;
      end
      W_WAVE_TAG: begin
        if (tag_acc != rwcp_pkg::TAG_WAVE) return rwcp_pkg::ST_NOT_WAVE;
        if (file_size < 32'd8 || file_size - 32'd8 != riff_len)
          return rwcp_pkg::ST_SIZE_MISMATCH;
        if (64'd12 >= {32'd0, riff_len} + 64'd8) return rwcp_pkg::ST_MISSING;
        tag_acc = '0;
        walk    = W_CK_TAG;
      end
      W_CK_TAG: begin
        skip_left = '0;
        walk      = W_CK_LEN;
      end
      default: return close_chunk_header();
    endcase
    return rwcp_pkg::ST_PENDING;
  endfunction

  function automatic status_rec_t parse_byte(input byte_item_t it);
    status_rec_t       rec;
    rwcp_pkg::status_e st;
    logic [31:0]       part;
    st = rwcp_pkg::ST_PENDING;
    if (it.first) begin
      walk          = W_RIFF_TAG;
      pos           = '0;
      shift         = 0;
      riff_len      = '0;
      file_size     = it.flen;
      tag_acc       = '0;
      skip_left     = '0;
      fmt_found     = 1'b0;
      data_found    = 1'b0;
      fmt_at        = '0;
      data_at       = '0;
      data_len_held = '0;
    end
    if (walk == W_IDLE) begin
      st = rwcp_pkg::ST_IGNORED;
    end else begin
      if (walk == W_SKIP) begin
        skip_left = skip_left - 64'd1;
        if (skip_left == 64'd0) walk = W_CK_TAG;
      end else begin
        part = {24'd0, it.value} << shift;
        if (walk == W_RIFF_LEN) riff_len = riff_len | part;
        else if (walk == W_CK_LEN) skip_left = skip_left | {32'd0, part};
        else tag_acc = tag_acc | part;
        shift = shift + 8;
        if (shift >= 32) begin
          shift = 0;
          st    = close_word();
        end
      end
      if (st == rwcp_pkg::ST_PENDING && it.last) st = rwcp_pkg::ST_MISSING;
      if (st != rwcp_pkg::ST_PENDING) walk = W_IDLE;
      pos = pos + 64'd1;
    end
    rec.status   = st;
    rec.fmt_off  = (st == rwcp_pkg::ST_FOUND) ? fmt_at[31:0] : 32'd0;
    rec.data_off = (st == rwcp_pkg::ST_FOUND) ? data_at[31:0] : 32'd0;
    rec.data_len = (st == rwcp_pkg::ST_FOUND) ? data_len_held : 32'd0;
    return rec;
  endfunction

  // Sender
  int unsigned src_gap    = 0;
  int unsigned src_win    = 0;
  bit          src_idle_ok = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && bif.ready) begin
        status_due_q.push_back(parse_byte(byte_q.pop_front()));
      end
      if (src_win == 0) begin
        src_win     = $urandom_range(20, 80);
        src_idle_ok = ($urandom_range(0, 1) == 1);
      end else begin
        src_win--;
      end
      // hold the current item until it transfers
      if (!src_valid || bif.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (!calm && src_idle_ok && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 11);
          src_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          src_valid <= 1'b1;
          src_value <= byte_q[0].value;
          src_first <= byte_q[0].first;
          src_last  <= byte_q[0].last;
          src_flen  <= byte_q[0].flen;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  int unsigned snk_gap     = 0;
  int unsigned snk_win     = 0;
  bit          snk_idle_ok = 1'b0;
  int unsigned hold_left   = 0;
  bit          long_held   = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    status_rec_t exp_rec;
    bit          take;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      if (sif.valid && snk_ready) begin
        results_seen++;
        if (status_due_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected status %0d at result %0d", sif.status, results_seen);
          fail_count++;
        end else begin
          exp_rec = status_due_q.pop_front();
          if (sif.status !== exp_rec.status || sif.format_offset !== exp_rec.fmt_off ||
              sif.data_offset !== exp_rec.data_off || sif.data_length !== exp_rec.data_len) begin
            if (fail_count < 10)
              $display("mismatch at result %0d: expected st=%0d fo=%h do=%h dl=%h, got st=%0d fo=%h do=%h dl=%h",
                       results_seen, exp_rec.status, exp_rec.fmt_off, exp_rec.data_off,
                       exp_rec.data_len, sif.status, sif.format_offset, sif.data_offset,
                       sif.data_length);
            fail_count++;
          end
        end
      end
      if (snk_win == 0) begin
        snk_win     = $urandom_range(20, 80);
        snk_idle_ok = ($urandom_range(0, 1) == 1);
      end else begin
        snk_win--;
      end
      take = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!long_held && results_seen >= 300) begin
        // back up the block so that it stalls its input
        long_held = 1'b1;
        hold_left = LONG_HOLD - 1;
        take      = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        take = 1'b0;
      end else if (!calm && snk_idle_ok && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 11);
        take    = 1'b0;
      end
      snk_ready <= take;
    end
  end

  // Watchdog
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((src_valid && bif.ready) || (sif.valid && snk_ready) ||
          (byte_q.size() == 0 && status_due_q.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic put_word(input logic [31:0] w);
    file_buf.push_back(w[7:0]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[23:16]);
    file_buf.push_back(w[31:24]);
  endtask

  task automatic open_wave();
    file_buf.delete();
    put_word(rwcp_pkg::TAG_RIFF);
    put_word(32'd0);
    put_word(rwcp_pkg::TAG_WAVE);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len, input int body);
    put_word(tag);
    put_word(len);
    repeat (body) file_buf.push_back(8'($urandom_range(0, 255)));
    if (body % 2 == 1) file_buf.push_back(8'd0);
  endtask

  task automatic put_junk_chunk();
    int body;
    body = $urandom_range(0, 7);
    put_chunk($urandom(), 32'(body), body);
  endtask

  task automatic set_declared(input logic [31:0] d);
    file_buf[4] = d[7:0];
    file_buf[5] = d[15:8];
    file_buf[6] = d[23:16];
    file_buf[7] = d[31:24];
  endtask

  task automatic seal_length();
    set_declared(32'(file_buf.size()) - 32'd8);
  endtask

  task automatic cut_to(input int keep);
    while (file_buf.size() > keep) void'(file_buf.pop_back());
  endtask

  task automatic send_file(input logic [31:0] flen, input bit mark_last);
    byte_item_t it;
    for (int i = 0; i < file_buf.size(); i++) begin
      it.value = file_buf[i];
      it.first = (i == 0);
      it.last  = mark_last && (i == file_buf.size() - 1);
      it.flen  = (i == 0) ? flen : $urandom();
      byte_q.push_back(it);
    end
    bytes_built += file_buf.size();
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || status_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_random_file();
    logic [31:0] flen;
    logic [31:0] fmt_len;
    logic [31:0] dat_len;
    bit          mark_last;
    int          idx;
    byte_item_t  it;
    if ($urandom_range(0, 7) == 0) begin
      // stray bytes, mostly outside any file
      repeat ($urandom_range(1, 4)) begin
        it.value = 8'($urandom_range(0, 255));
        it.first = ($urandom_range(0, 3) == 0);
        it.last  = ($urandom_range(0, 1) == 1);
        it.flen  = $urandom();
        byte_q.push_back(it);
      end
    end
    open_wave();
    repeat ($urandom_range(0, 2)) put_junk_chunk();
    fmt_len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 13))
                                          : 32'($urandom_range(14, 20));
    dat_len = 32'($urandom_range(0, 9));
    if ($urandom_range(0, 1) == 1) begin
      put_chunk(rwcp_pkg::TAG_FMT, fmt_len, int'(fmt_len));
      if ($urandom_range(0, 3) == 0) put_junk_chunk();
      put_chunk(rwcp_pkg::TAG_DATA, dat_len, int'(dat_len));
    end else begin
      put_chunk(rwcp_pkg::TAG_DATA, dat_len, int'(dat_len));
      if ($urandom_range(0, 3) == 0) put_junk_chunk();
      if ($urandom_range(0, 3) == 0) put_chunk(rwcp_pkg::TAG_DATA, 32'd3, 3);
      put_chunk(rwcp_pkg::TAG_FMT, fmt_len, int'(fmt_len));
    end
    if ($urandom_range(0, 2) == 0) put_chunk(rwcp_pkg::TAG_DATA, 32'd2, 2);
    seal_length();
    flen      = 32'(file_buf.size());
    mark_last = 1'b1;
    case ($urandom_range(0, 9))
      0: begin
        idx = $urandom_range(0, 11);
        file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      1: flen = $urandom();
      2: cut_to($urandom_range(1, file_buf.size() - 1));
      3: begin
        idx = $urandom_range(4, file_buf.size() - 9);
        set_declared(32'(idx));
        flen = 32'(idx) + 32'd8;
      end
      4: begin
        cut_to($urandom_range(1, file_buf.size() - 1));
        mark_last = 1'b0;
      end
      5: mark_last = 1'b0;
      default: ;
    endcase
    send_file(flen, mark_last);
  endtask

  initial begin
    byte_item_t  it;
    int unsigned keep;
    int unsigned random_start;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bytes ahead of any file
    it = '{value: 8'hA5, first: 1'b0, last: 1'b1, flen: 32'hFFFF_FFFF};
    byte_q.push_back(it);
    it = '{value: 8'h5A, first: 1'b0, last: 1'b0, flen: 32'd0};
    byte_q.push_back(it);
    // one-byte stream: first and last together
    it = '{value: 8'h52, first: 1'b1, last: 1'b1, flen: 32'd1};
    byte_q.push_back(it);

    file_buf.delete();
    put_word(rwcp_pkg::TAG_RIFF ^ 32'h0100_0000);
    send_file(32'd4, 1'b0);

    open_wave();
    seal_length();
    file_buf[8] = file_buf[8] ^ 8'h20;
    send_file(32'd12, 1'b0);

    // file length below the header size
    open_wave();
    set_declared(32'hFFFF_FFFC);
    send_file(32'd4, 1'b0);

    open_wave();
    set_declared(32'd4);
    send_file(32'd12, 1'b0);

    open_wave();
    put_chunk(rwcp_pkg::TAG_FMT, 32'd13, 13);
    seal_length();
    send_file(32'(file_buf.size()), 1'b1);

    // odd chunk, later fmt ignored, huge data length
    open_wave();
    put_chunk(32'h5453_494C, 32'd3, 3);
    put_chunk(rwcp_pkg::TAG_FMT, 32'd16, 16);
    put_chunk(rwcp_pkg::TAG_FMT, 32'd4, 4);
    put_chunk(rwcp_pkg::TAG_DATA, 32'hFFFF_FFFE, 0);
    set_declared(32'hFFFF_FFF7);
    send_file(32'hFFFF_FFFF, 1'b1);

    // restart in the middle of a file
    open_wave();
    put_chunk(rwcp_pkg::TAG_FMT, 32'd16, 16);
    seal_length();
    cut_to(10);
    send_file(32'd36, 1'b0);

    open_wave();
    put_chunk(rwcp_pkg::TAG_DATA, 32'd0, 0);
    put_chunk(rwcp_pkg::TAG_FMT, 32'd14, 14);
    put_chunk(rwcp_pkg::TAG_DATA, 32'd6, 6);
    seal_length();
    send_file(32'(file_buf.size()), 1'b1);

    open_wave();
    put_chunk(rwcp_pkg::TAG_FMT, 32'd14, 14);
    put_chunk(rwcp_pkg::TAG_DATA, 32'd0, 0);
    seal_length();
    send_file(32'(file_buf.size()), 1'b1);

    open_wave();
    put_chunk(rwcp_pkg::TAG_DATA, 32'd5, 5);
    put_chunk(rwcp_pkg::TAG_DATA, 32'd7, 7);
    put_chunk(rwcp_pkg::TAG_FMT, 32'd18, 18);
    seal_length();
    send_file(32'(file_buf.size()), 1'b0);

    // padding of the largest length must not wrap
    open_wave();
    put_chunk(32'h4B4E_554A, 32'hFFFF_FFFF, 0);
    set_declared(32'hFFFF_FFF7);
    send_file(32'hFFFF_FFFF, 1'b0);

    // walk runs into the declared end
    open_wave();
    put_chunk(rwcp_pkg::TAG_FMT, 32'd16, 16);
    seal_length();
    keep = file_buf.size();
    put_chunk(rwcp_pkg::TAG_DATA, 32'd4, 4);
    send_file(32'(keep), 1'b1);

    // stream ends before the walk finishes
    open_wave();
    put_chunk(rwcp_pkg::TAG_FMT, 32'd16, 16);
    put_chunk(rwcp_pkg::TAG_DATA, 32'd4, 4);
    seal_length();
    keep = file_buf.size();
    cut_to(20);
    send_file(32'(keep), 1'b1);

    wait_drained();

    // closing stretch of random files with no idling
    calm         = 1'b1;
    random_start = bytes_built;
    while (bytes_built - random_start < 60) begin
      while (byte_q.size() > 32) @(posedge clk_i);
      add_random_file();
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
